### hw/rtl/ftfe_pkg.sv
// Shared types, constants and codes for the falling trail frame effect.
`default_nettype none
package ftfe_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 8;

  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int FADE_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam logic [PIX_W-1:0]  HEAD_RST  = 24'hAFFFAF;
  localparam logic [PIX_W-1:0]  TRAIL_RST = 24'h1B8227;
  localparam logic [FADE_W-1:0] FADE_RST  = 9'd192;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD  = 2'd0,
    REG_TRAIL = 2'd1,
    REG_FADE  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_STEP,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic        spawn;
    logic [4:0]  spawn_column;
    logic [4:0]  read_column;
    logic [2:0]  read_row;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } out_beat_t;

  typedef struct packed {
    logic row1;
    logic spawn_hit;
  } pix_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/ftfe_mem.sv
// Frame store RAM: one write port, one read port with registered read data.
`default_nettype none
module ftfe_mem #(
  parameter int DEPTH = ftfe_pkg::COLUMNS_DEF * ftfe_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [ftfe_pkg::PIX_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output logic      [ftfe_pkg::PIX_W-1:0] rdata
);
  import ftfe_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ftfe_pix.sv
// Pixel update datapath: head substitution, per-channel fade, head overrides.
`default_nettype none
module ftfe_pix (
  input  wire logic [ftfe_pkg::PIX_W-1:0]  src,
  input  wire logic [ftfe_pkg::PIX_W-1:0]  head_color,
  input  wire logic [ftfe_pkg::PIX_W-1:0]  trail_rgb,
  input  wire logic [ftfe_pkg::FADE_W-1:0] fade_numerator,
  input  wire ftfe_pkg::pix_ctl_t          ctl,
  output logic      [ftfe_pkg::PIX_W-1:0]  dst
);
  import ftfe_pkg::*;

  function automatic logic [CH_W-1:0] fade_ch(input logic [CH_W-1:0] ch,
                                              input logic [FADE_W-1:0] num);
    logic [CH_W+FADE_W-1:0] prod;
    logic [FADE_W-1:0]      sh;
    prod = (CH_W+FADE_W)'(ch) * (CH_W+FADE_W)'(num);
    sh   = prod[CH_W+FADE_W-1:CH_W];
    return sh[FADE_W-1] ? {CH_W{1'b1}} : sh[CH_W-1:0];
  endfunction

  logic             is_head;
  logic [PIX_W-1:0] base;
  logic [PIX_W-1:0] faded;

  always_comb begin
    is_head = (src == head_color);
    base    = is_head ? trail_rgb : src;
    faded   = {fade_ch(base[23:16], fade_numerator),
               fade_ch(base[15:8], fade_numerator),
               fade_ch(base[7:0], fade_numerator)};
    if ((ctl.row1 && is_head) || ctl.spawn_hit) begin
      dst = head_color;
    end else begin
      dst = faded;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/falling_trail_frame_effect.sv
// Top level: sequencer, configuration registers and result register.
//
// Falling trail effect over a COLUMNS x ROWS RGB888 frame held in one
// single-port-write RAM. Every item gives one result beat. A step item
// sweeps the frame bottom to top, one pixel per cycle; a clear item
// writes zeros one pixel per cycle. The RAM port, one pixel per cycle,
// sets this sweep rate. After reset the block clears the RAM and accepts
// no item meanwhile. Items are taken one at a time; the user must write
// configuration only while the block is idle, which the block itself
// does not enforce.
`default_nettype none
module falling_trail_frame_effect #(
  parameter int COLUMNS = ftfe_pkg::COLUMNS_DEF,
  parameter int ROWS    = ftfe_pkg::ROWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ftfe_pkg::in_beat_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ftfe_pkg::out_beat_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [ftfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ftfe_pkg::CFG_W-1:0]   cfg_wdata
);
  import ftfe_pkg::*;

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              spawn_ok_r, spawn_ok_nxt;
  logic [4:0]        spawn_col_r, spawn_col_nxt;
  logic              p_valid_r, p_valid_nxt;
  logic [AW-1:0]     p_addr_r, p_addr_nxt;
  pix_ctl_t          p_ctl_r, p_ctl_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;
  logic [PIX_W-1:0]  head_r, trail_r;
  logic [FADE_W-1:0] fade_r;

  logic              mem_we, mem_re, clr_we, out_free;
  logic              row0, row1, rd_in_range, spawn_in_range;
  logic [AW-1:0]     mem_waddr, mem_raddr, rd_addr;
  logic [PIX_W-1:0]  mem_wdata, mem_rdata, pix_out;

  ftfe_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ftfe_pix u_pix (
    .src            (mem_rdata),
    .head_color     (head_r),
    .trail_rgb      (trail_r),
    .fade_numerator (fade_r),
    .ctl            (p_ctl_r),
    .dst            (pix_out)
  );

  assign row0           = (addr_r < COLS_A);
  assign row1           = !row0 && ((addr_r - COLS_A) < COLS_A);
  assign rd_in_range    = (32'(in_data.read_column) < COLUMNS) &&
                          (32'(in_data.read_row) < ROWS);
  assign spawn_in_range = (32'(in_data.spawn_column) < COLUMNS);
  assign rd_addr        = AW'(AW'(in_data.read_row) * COLS_A) +
                          AW'(in_data.read_column);
  assign out_free       = !out_valid_r || out_ready;

  assign mem_we    = clr_we || p_valid_r;
  assign mem_waddr = p_valid_r ? p_addr_r : addr_r;
  assign mem_wdata = p_valid_r ? pix_out : '0;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    spawn_ok_nxt  = spawn_ok_r;
    spawn_col_nxt = spawn_col_r;
    p_valid_nxt   = 1'b0;
    p_addr_nxt    = addr_r;
    p_ctl_nxt     = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;
    clr_we        = 1'b0;
    in_ready      = (state_r == ST_IDLE);
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        clr_we = 1'b1;
        if (addr_r == '0) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          addr_nxt = addr_r - 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            KIND_CLEAR: begin
              addr_nxt  = LAST_A;
              state_nxt = ST_CLEAR;
            end
            KIND_STEP: begin
              addr_nxt      = LAST_A;
              spawn_ok_nxt  = in_data.spawn && spawn_in_range;
              spawn_col_nxt = in_data.spawn_column;
              state_nxt     = ST_STEP;
            end
            KIND_READ: begin
              if (rd_in_range) begin
                mem_re    = 1'b1;
                mem_raddr = rd_addr;
                state_nxt = ST_READ;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_STEP: begin
        mem_re              = 1'b1;
        mem_raddr           = row0 ? addr_r : addr_r - COLS_A;
        p_valid_nxt         = 1'b1;
        p_addr_nxt          = addr_r;
        p_ctl_nxt.row1      = row1;
        p_ctl_nxt.spawn_hit = row0 && spawn_ok_r && (addr_r == AW'(spawn_col_r));
        if (addr_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          addr_nxt = addr_r - 1'b1;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {mem_rdata[23:16], mem_rdata[15:8], mem_rdata[7:0]};
          state_nxt     = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= LAST_A;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      spawn_ok_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      spawn_ok_r  <= spawn_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spawn_col_r <= spawn_col_nxt;
    p_addr_r    <= p_addr_nxt;
    p_ctl_r     <= p_ctl_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= HEAD_RST;
      trail_r <= TRAIL_RST;
      fade_r  <= FADE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD:  head_r  <= cfg_wdata[PIX_W-1:0];
        REG_TRAIL: trail_r <= cfg_wdata[PIX_W-1:0];
        REG_FADE:  fade_r  <= cfg_wdata[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pipe_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == ST_STEP || state_r == ST_DONE))
    else $error("pixel write outside step sweep");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!p_valid_r && !mem_we))
    else $error("beat accepted while frame store busy");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_READ) |-> !mem_we)
    else $error("frame store written while idle or reading");

  a_step_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && addr_r == '0) |=> (state_r == ST_DONE && p_valid_r))
    else $error("step sweep did not finish with final write");

endmodule
`default_nettype wire
